### design/shd_pkg.sv
// Shared types and constants for the sync header XOR deframer.
package shd_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CFG_INDEX_W = 8;

    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_SYNC_FIRST = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_SYNC_SECOND = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_ID_A = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_ID_B = 8'd3;

    localparam logic [BYTE_W-1:0] SYNC_FIRST_RST = 8'h55;
    localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'hAA;
    localparam logic [BYTE_W-1:0] ID_A_RST = 8'h01;
    localparam logic [BYTE_W-1:0] ID_B_RST = 8'h05;

    localparam int unsigned ID_POS = 2;
    localparam int unsigned LEN_POS = 3;

    localparam logic [1:0] ST_GOOD = 2'd0;
    localparam logic [1:0] ST_BAD_ID = 2'd1;
    localparam logic [1:0] ST_BAD_SUM = 2'd2;

    typedef enum logic [2:0] {
        PH_HEADER = 3'b001,
        PH_BODY = 3'b010,
        PH_HUNT = 3'b100
    } phase_t;

    typedef struct packed {
        logic [BYTE_W-1:0] sync_first;
        logic [BYTE_W-1:0] sync_second;
        logic [BYTE_W-1:0] id_a;
        logic [BYTE_W-1:0] id_b;
    } cfg_t;

    typedef struct packed {
        logic [BYTE_W-1:0] payload_byte;
        logic payload_valid;
        logic [BYTE_W-1:0] packet_id;
        logic frame_end;
        logic [1:0] frame_status;
        logic in_sync;
    } res_t;

endpackage

### design/shd_cfg_regs.sv
// Configuration register file for the deframer.
module shd_cfg_regs
    import shd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  logic [CFG_INDEX_W-1:0] wr_index,
    input  logic [BYTE_W-1:0] wr_data,
    output cfg_t cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                CFG_IDX_SYNC_FIRST:  cfg_next.sync_first = wr_data;
                CFG_IDX_SYNC_SECOND: cfg_next.sync_second = wr_data;
                CFG_IDX_ID_A:        cfg_next.id_a = wr_data;
                CFG_IDX_ID_B:        cfg_next.id_b = wr_data;
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sync_first <= SYNC_FIRST_RST;
            cfg_reg.sync_second <= SYNC_SECOND_RST;
            cfg_reg.id_a <= ID_A_RST;
            cfg_reg.id_b <= ID_B_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### design/shd_frame_core.sv
// Framing state machine: header collection, body XOR check and sync hunt.
module shd_frame_core
    import shd_pkg::*;
#(
    parameter int unsigned HEADER_BYTES = 6
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic step,
    input  logic [BYTE_W-1:0] rx_byte,
    input  logic line_error,
    input  cfg_t cfg,
    output res_t res
);

    localparam int unsigned CNT_W = $clog2(HEADER_BYTES);
    localparam logic [CNT_W-1:0] LAST_POS = CNT_W'(HEADER_BYTES - 1);
    localparam logic [CNT_W-1:0] ID_CNT = CNT_W'(ID_POS);
    localparam logic [CNT_W-1:0] LEN_CNT = CNT_W'(LEN_POS);

    phase_t phase_reg;
    phase_t phase_next;
    logic [CNT_W-1:0] hdr_cnt_reg;
    logic [CNT_W-1:0] hdr_cnt_next;
    logic [BYTE_W-1:0] prev_byte_reg;
    logic [BYTE_W-1:0] prev_byte_next;
    logic [BYTE_W-1:0] frame_id_reg;
    logic [BYTE_W-1:0] frame_id_next;
    logic [BYTE_W-1:0] body_len_reg;
    logic [BYTE_W-1:0] body_len_next;
    logic [BYTE_W-1:0] exp_sum_reg;
    logic [BYTE_W-1:0] exp_sum_next;
    logic [BYTE_W-1:0] run_xor_reg;
    logic [BYTE_W-1:0] run_xor_next;
    logic [BYTE_W-1:0] body_cnt_reg;
    logic [BYTE_W-1:0] body_cnt_next;
    logic go_hunt;
    logic [BYTE_W-1:0] len_now;

    always_comb
    begin
        phase_next = phase_reg;
        hdr_cnt_next = hdr_cnt_reg;
        prev_byte_next = prev_byte_reg;
        frame_id_next = frame_id_reg;
        body_len_next = body_len_reg;
        exp_sum_next = exp_sum_reg;
        run_xor_next = run_xor_reg;
        body_cnt_next = body_cnt_reg;
        go_hunt = 1'b0;
        len_now = body_len_reg;

        res.payload_byte = '0;
        res.payload_valid = 1'b0;
        res.packet_id = frame_id_reg;
        res.frame_end = 1'b0;
        res.frame_status = ST_GOOD;

        if (line_error)
        begin
            go_hunt = 1'b1;
        end
        else
        begin
            unique case (phase_reg)
                PH_HEADER:
                begin
                    if (hdr_cnt_reg == ID_CNT && rx_byte != cfg.id_a && rx_byte != cfg.id_b)
                    begin
                        res.frame_end = 1'b1;
                        res.frame_status = ST_BAD_ID;
                        res.packet_id = rx_byte;
                        go_hunt = 1'b1;
                    end
                    else
                    begin
                        if (hdr_cnt_reg == ID_CNT)
                        begin
                            frame_id_next = rx_byte;
                            res.packet_id = rx_byte;
                        end
                        if (hdr_cnt_reg == LEN_CNT)
                        begin
                            len_now = rx_byte;
                        end
                        body_len_next = len_now;
                        if (hdr_cnt_reg == LAST_POS)
                        begin
                            exp_sum_next = rx_byte;
                            hdr_cnt_next = '0;
                            run_xor_next = '0;
                            body_cnt_next = '0;
                            if (len_now == '0)
                            begin
                                res.frame_end = 1'b1;
                                if (rx_byte == '0)
                                begin
                                    res.frame_status = ST_GOOD;
                                    phase_next = PH_HEADER;
                                end
                                else
                                begin
                                    res.frame_status = ST_BAD_SUM;
                                    go_hunt = 1'b1;
                                end
                            end
                            else
                            begin
                                phase_next = PH_BODY;
                            end
                        end
                        else
                        begin
                            hdr_cnt_next = hdr_cnt_reg + 1'b1;
                        end
                    end
                end
                PH_BODY:
                begin
                    res.payload_byte = rx_byte;
                    res.payload_valid = 1'b1;
                    run_xor_next = run_xor_reg ^ rx_byte;
                    body_cnt_next = body_cnt_reg + 1'b1;
                    if (body_cnt_next == body_len_reg)
                    begin
                        res.frame_end = 1'b1;
                        if (run_xor_next == exp_sum_reg)
                        begin
                            res.frame_status = ST_GOOD;
                            phase_next = PH_HEADER;
                            hdr_cnt_next = '0;
                        end
                        else
                        begin
                            res.frame_status = ST_BAD_SUM;
                            go_hunt = 1'b1;
                        end
                    end
                end
                default:
                begin
                    if (rx_byte == cfg.sync_second && prev_byte_reg == cfg.sync_first)
                    begin
                        phase_next = PH_HEADER;
                        hdr_cnt_next = ID_CNT;
                    end
                    else
                    begin
                        phase_next = PH_HUNT;
                        prev_byte_next = rx_byte;
                    end
                end
            endcase
        end

        if (go_hunt)
        begin
            phase_next = PH_HUNT;
            prev_byte_next = '0;
            hdr_cnt_next = '0;
        end

        res.in_sync = (phase_next == PH_HEADER) || (phase_next == PH_BODY);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            hdr_cnt_reg <= '0;
            prev_byte_reg <= '0;
            frame_id_reg <= '0;
            body_len_reg <= '0;
            exp_sum_reg <= '0;
            run_xor_reg <= '0;
            body_cnt_reg <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            hdr_cnt_reg <= hdr_cnt_next;
            prev_byte_reg <= prev_byte_next;
            frame_id_reg <= frame_id_next;
            body_len_reg <= body_len_next;
            exp_sum_reg <= exp_sum_next;
            run_xor_reg <= run_xor_next;
            body_cnt_reg <= body_cnt_next;
        end
    end

endmodule

### design/sync_header_xor_deframer.sv
// Top level of the sync header XOR deframer: input and result registers.
//
// Received bytes enter on the item channel (item_valid, item_stall) with
// rx_byte and line_error; each accepted item gives exactly one result on the
// result channel (result_valid, result_stall). A result carries the body byte
// when payload_valid is set, the packet ID, the frame end flag with its
// status, and the alignment flag. Configuration registers (sync pair and the
// two accepted IDs) are written through cfg_valid/cfg_ready with cfg_index
// and cfg_data; cfg_ready is always high, and writes belong to idle periods.
// An item is held in the input register, is processed by the framing logic
// and lands in the result register, where its result is presented; one item
// is taken every cycle while the receiver does not stall, limited only by
// the single framing state update.
// While the receiver stalls, the result register holds; the input register
// still takes one more item and then stalls the sender.
// Reset puts the deframer into header collection as if aligned, with all
// counters and checksum state cleared and the configuration registers at their defaults.
module sync_header_xor_deframer
    import shd_pkg::*;
#(
    parameter int unsigned HEADER_BYTES = 6
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic item_valid,
    output logic item_stall,
    input  logic [BYTE_W-1:0] rx_byte,
    input  logic line_error,
    output logic result_valid,
    input  logic result_stall,
    output logic [BYTE_W-1:0] payload_byte,
    output logic payload_valid,
    output logic [BYTE_W-1:0] packet_id,
    output logic frame_end,
    output logic [1:0] frame_status,
    output logic in_sync,
    input  logic cfg_valid,
    output logic cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [BYTE_W-1:0] cfg_data
);

    cfg_t cfg;
    res_t res;
    res_t res_reg;
    logic item_vld_reg;
    logic item_vld_next;
    logic [BYTE_W-1:0] rx_byte_reg;
    logic line_error_reg;
    logic result_valid_reg;
    logic result_valid_next;
    logic advance;
    logic accept;

    assign cfg_ready = 1'b1;

    shd_cfg_regs u_cfg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    shd_frame_core #(
        .HEADER_BYTES (HEADER_BYTES)
    ) u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (advance),
        .rx_byte    (rx_byte_reg),
        .line_error (line_error_reg),
        .cfg        (cfg),
        .res        (res)
    );

    assign advance = item_vld_reg && (!result_valid_reg || !result_stall);
    assign item_stall = item_vld_reg && !advance;
    assign accept = item_valid && !item_stall;

    always_comb
    begin
        item_vld_next = item_vld_reg;
        if (accept)
        begin
            item_vld_next = 1'b1;
        end
        else if (advance)
        begin
            item_vld_next = 1'b0;
        end

        result_valid_next = result_valid_reg;
        if (advance)
        begin
            result_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_vld_reg <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            item_vld_reg <= item_vld_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rx_byte_reg <= rx_byte;
            line_error_reg <= line_error;
        end
        if (advance)
        begin
            res_reg <= res;
        end
    end

    assign result_valid = result_valid_reg;
    assign payload_byte = res_reg.payload_byte;
    assign payload_valid = res_reg.payload_valid;
    assign packet_id = res_reg.packet_id;
    assign frame_end = res_reg.frame_end;
    assign frame_status = res_reg.frame_status;
    assign in_sync = res_reg.in_sync;

    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !frame_end) |-> (frame_status == ST_GOOD))
        else $error("Status reported without a frame end.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && frame_status == ST_BAD_ID) |-> (!payload_valid && !in_sync))
        else $error("Unknown ID rejection did not drop alignment.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && frame_status == ST_BAD_SUM) |-> (frame_end && !in_sync))
        else $error("Checksum mismatch did not enter hunt mode.");

    assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> (result_valid && result_stall))
        else $error("Input stalled while the result side was free.");

endmodule
